@@ rtl/mfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants
// Command codes, framebuffer geometry and the video control word.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int CMD_W      = 3;
    localparam int PIX_W      = 9;
    localparam int COLOR_W    = 24;
    localparam int MEM_DEPTH  = 1 << ADDR_W;

    localparam int ROM_BYTES  = 8192;
    localparam int FB_WIDTH   = 512;
    localparam int FB_HEIGHT  = 384;
    localparam int FB_ROW_BYTES = FB_WIDTH / 8;
    localparam logic [ADDR_W-1:0] FB_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] DEBUG_TOP = 16'h0004;
    localparam logic [7:0] CTL_PORT = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_MEM_RD  = 3'd0,
        CMD_MEM_WR  = 3'd1,
        CMD_IO_RD   = 3'd2,
        CMD_IO_WR   = 3'd3,
        CMD_PIXEL   = 3'd4,
        CMD_PRELOAD = 3'd5
    } t_cmd;

    typedef struct packed {
        logic               mode;
        logic               blank;
        logic [COLOR_W-1:0] color;
    } t_video_ctl;

endpackage

@@ rtl/mfb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_if: stream interfaces
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfb_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [mfb_pkg::CMD_W-1:0]   cmd;
    logic [mfb_pkg::ADDR_W-1:0]  address;
    logic [mfb_pkg::DATA_W-1:0]  data;
    logic [mfb_pkg::PIX_W-1:0]   pixel_x;
    logic [mfb_pkg::PIX_W-1:0]   pixel_y;

    modport source (output valid, cmd, address, data, pixel_x, pixel_y, input ready);
    modport sink   (input valid, cmd, address, data, pixel_x, pixel_y, output ready);
endinterface

interface mfb_res_if;
    logic                         valid;
    logic                         ready;
    logic [mfb_pkg::DATA_W-1:0]   read_data;
    logic [mfb_pkg::COLOR_W-1:0]  pixel_color;
    logic                         pixel_on;
    logic                         video_mode;
    logic                         blanked;

    modport source (output valid, read_data, pixel_color, pixel_on, video_mode, blanked,
                    input ready);
    modport sink   (input valid, read_data, pixel_color, pixel_on, video_mode, blanked,
                    output ready);
endinterface

@@ rtl/mfb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_ram: 64K x 8 single-port memory
// Synchronous write, registered read data.
// ----------------------------------------------------------------------------
module mfb_ram (
    input  logic                        i_clk,
    input  logic                        i_rd,
    input  logic                        i_wr,
    input  logic [mfb_pkg::ADDR_W-1:0]  i_addr,
    input  logic [mfb_pkg::DATA_W-1:0]  i_wdata,
    output logic [mfb_pkg::DATA_W-1:0]  o_rdata
);
    import mfb_pkg::*;

    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mfb_ctl_port.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_ctl_port: video control port
// Port 1 write sets mode, blank and a 2-2-2 foreground color.
// ----------------------------------------------------------------------------
module mfb_ctl_port (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_io_wr,
    input  logic [7:0]                  i_port,
    input  logic [mfb_pkg::DATA_W-1:0]  i_data,
    output mfb_pkg::t_video_ctl         o_ctl
);
    import mfb_pkg::*;

    t_video_ctl r_ctl;
    t_video_ctl n_ctl;

    // each 2-bit field lands in the top two bits of its channel
    always_comb begin
        n_ctl       = r_ctl;
        if (i_io_wr && (i_port == CTL_PORT)) begin
            n_ctl.mode  = i_data[7];
            n_ctl.blank = ~i_data[6];
            n_ctl.color = {i_data[5:4], 6'd0, i_data[3:2], 6'd0, i_data[1:0], 6'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    assign o_ctl = r_ctl;

endmodule

@@ rtl/mono_framebuffer_video_bus.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_video_bus: video board bus and framebuffer lookup
// 64 KB memory map with write-protected ROM, control port and pixel reads.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd_ch carries one command per transfer: memory read/write, I/O
//   read/write, pixel lookup or preload. o_res_ch returns exactly one result
//   transfer per command, in order.
//   Throughput: one command per clock while o_res_ch.ready is high. Every
//   command touches the single memory port once (read, write or nothing)
//   in its accept cycle. Result path: the RAM read data registers on the
//   accept edge, then the output register loads from it when it is free,
//   and o_res_ch.valid comes from the output register.
//   Stall: when o_res_ch.ready is low, the result holds in the output
//   register and one more command may sit in the read stage; beyond that
//   i_cmd_ch.ready drops until the receiver takes a transfer.
//   Reset: synchronous, active low. Clears handshake state and the control
//   port (mode 0, blank 0, black foreground). Memory is not cleared; reading
//   a byte never written returns whatever the RAM holds.
//   Mode and blank in a result are the values after that command's update.
// ----------------------------------------------------------------------------
module mono_framebuffer_video_bus (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfb_cmd_if.sink     i_cmd_ch,
    mfb_res_if.source   o_res_ch
);
    import mfb_pkg::*;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_BYTE,
        RES_PIXEL
    } t_res_kind;

    // handshake
    logic w_accept;
    logic w_out_free;
    logic w_s1_adv;

    // memory access decode
    logic              w_rd;
    logic              w_wr;
    logic [ADDR_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_pix_addr;
    logic              w_pix_in;
    logic              w_wr_ok;
    t_res_kind         w_kind;
    logic [DATA_W-1:0] w_rdata;

    // read stage
    logic      r_s1_valid;
    t_res_kind r_s1_kind;
    logic [2:0] r_s1_bit;

    // output register
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_rd;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_on;
    logic               r_out_mode;
    logic               r_out_blank;

    t_video_ctl w_ctl;
    logic       w_bit;

    assign w_out_free = !r_out_valid || o_res_ch.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign i_cmd_ch.ready = !r_s1_valid || w_out_free;
    assign w_accept   = i_cmd_ch.valid && i_cmd_ch.ready;

    // bitmap byte: base + row * bytes_per_row + column / 8, wrapped to 16 bits
    assign w_pix_addr = FB_BASE
                      + ADDR_W'({7'd0, i_cmd_ch.pixel_y} * ADDR_W'(FB_ROW_BYTES))
                      + ADDR_W'(i_cmd_ch.pixel_x >> 3);
    assign w_pix_in   = ({1'b0, i_cmd_ch.pixel_x} < 10'(FB_WIDTH))
                     && ({1'b0, i_cmd_ch.pixel_y} < 10'(FB_HEIGHT));
    // ROM and the debug addresses are write protected
    assign w_wr_ok    = (i_cmd_ch.address >= DEBUG_TOP)
                     && ({1'b0, i_cmd_ch.address} >= 17'(ROM_BYTES));

    always_comb begin
        w_rd   = 1'b0;
        w_wr   = 1'b0;
        w_addr = i_cmd_ch.address;
        w_kind = RES_ZERO;
        case (i_cmd_ch.cmd)
            CMD_MEM_RD: begin
                w_rd   = w_accept;
                w_kind = RES_BYTE;
            end
            CMD_MEM_WR: begin
                w_wr = w_accept && w_wr_ok;
            end
            CMD_PIXEL: begin
                w_addr = w_pix_addr;
                w_rd   = w_accept && w_pix_in;
                w_kind = w_pix_in ? RES_PIXEL : RES_ZERO;
            end
            CMD_PRELOAD: begin
                w_wr = w_accept;
            end
            default: begin
                w_kind = RES_ZERO;
            end
        endcase
    end

    mfb_ram u_ram (
        .i_clk   (i_clk),
        .i_rd    (w_rd),
        .i_wr    (w_wr),
        .i_addr  (w_addr),
        .i_wdata (i_cmd_ch.data),
        .o_rdata (w_rdata)
    );

    mfb_ctl_port u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_io_wr (w_accept && (i_cmd_ch.cmd == CMD_IO_WR)),
        .i_port  (i_cmd_ch.address[7:0]),
        .i_data  (i_cmd_ch.data),
        .o_ctl   (w_ctl)
    );

    // The next command is accepted only on the edge where the read stage
    // drains, so the control port seen here is still the value right after
    // the command in the read stage.
    assign w_bit = w_rdata[r_s1_bit];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind <= w_kind;
            r_s1_bit  <= i_cmd_ch.pixel_x[2:0];
        end
        if (w_s1_adv) begin
            r_out_rd    <= (r_s1_kind == RES_BYTE) ? w_rdata : '0;
            r_out_on    <= (r_s1_kind == RES_PIXEL) && w_bit;
            r_out_color <= ((r_s1_kind == RES_PIXEL) && w_bit) ? w_ctl.color : '0;
            r_out_mode  <= w_ctl.mode;
            r_out_blank <= w_ctl.blank;
        end
    end

    assign o_res_ch.valid       = r_out_valid;
    assign o_res_ch.read_data   = r_out_rd;
    assign o_res_ch.pixel_color = r_out_color;
    assign o_res_ch.pixel_on    = r_out_on;
    assign o_res_ch.video_mode  = r_out_mode;
    assign o_res_ch.blanked     = r_out_blank;

    // a waiting command stays in the read stage while the output is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> r_s1_valid)
        else $error("read stage lost a command under stall");

    // no new command while both stages are full and stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_res_ch.ready) |-> !i_cmd_ch.ready)
        else $error("command accepted with pipeline full");

    // pixel color only on a lit pixel
    a_dark_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_on) |-> (r_out_color == '0))
        else $error("color on a dark pixel");

    // pixel answers and byte reads never mix
    a_pixel_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_on) |-> (r_out_rd == '0))
        else $error("read data on a pixel result");

    // memory is only touched by an accepted command
    a_mem_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd || w_wr) |-> w_accept)
        else $error("memory access without a transfer");

endmodule

@@ test/tb_mono_framebuffer_video_bus.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_video_bus: bus and framebuffer lookup testbench
// Directed corner commands, then bursts of random bus traffic against a
// scoreboard that tracks the memory map and the control port. The command
// side idles in bursts, the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_video_bus;
    import mfb_pkg::*;

    // cmd codes 6 and 7 are not in the package enum; the block must ignore them
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int FB_END      = int'(FB_BASE) + FB_HEIGHT * FB_ROW_BYTES;
    localparam int RAND_ITEMS  = 1800;
    localparam int DRAIN_EVERY = 450;      // sender waits for an empty scoreboard this often
    localparam int TAIL_CYCLES = 8;        // leave slack for stray transfers
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  data;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
    } bus_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [COLOR_W-1:0] pixel_color;
        logic               pixel_on;
        logic               video_mode;
        logic               blanked;
    } bus_resp_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the memory map and control port, queues one
    // expected response per accepted command, checks responses in order.
    // ------------------------------------------------------------------------
    class vbus_scoreboard;
        logic [DATA_W-1:0] mem_image [0:MEM_DEPTH-1];
        t_video_ctl        ctl;
        bus_resp_t         expected_resp_q[$];
        int                mismatches;

        function new();
            ctl        = '0;       // reset: mode 0, blank 0, black
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_resp_q.size();
        endfunction

        function void accept_command(bus_cmd_t it);
            bus_resp_t         r;
            logic [ADDR_W-1:0] fb_addr;
            r = '0;
            case (it.cmd)
                CMD_MEM_RD: r.read_data = mem_image[it.address];
                CMD_MEM_WR: begin
                    // debug window and ROM are write protected
                    if (it.address >= DEBUG_TOP && it.address >= ROM_BYTES)
                        mem_image[it.address] = it.data;
                end
                CMD_IO_WR: begin
                    if (it.address[7:0] == CTL_PORT) begin
                        ctl.mode  = it.data[7];
                        ctl.blank = ~it.data[6];
                        // 2-2-2 color, each pair lands in the top of its channel
                        ctl.color = {it.data[5:4], 6'b0, it.data[3:2], 6'b0,
                                     it.data[1:0], 6'b0};
                    end
                end
                CMD_PIXEL: begin
                    if (it.pixel_x < FB_WIDTH && it.pixel_y < FB_HEIGHT) begin
                        fb_addr = ADDR_W'(int'(FB_BASE) + int'(it.pixel_y) * FB_ROW_BYTES
                                          + int'(it.pixel_x >> 3));
                        r.pixel_on    = mem_image[fb_addr][it.pixel_x[2:0]];
                        r.pixel_color = r.pixel_on ? ctl.color : '0;
                    end
                end
                CMD_PRELOAD: mem_image[it.address] = it.data;
                default: ;
            endcase
            r.video_mode = ctl.mode;
            r.blanked    = ctl.blank;
            expected_resp_q.push_back(r);
        endfunction

        function void check_response(bus_resp_t got);
            bus_resp_t exp_r;
            if (expected_resp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: response with nothing expected: rd=%h col=%h on=%b",
                             got.read_data, got.pixel_color, got.pixel_on);
                return;
            end
            exp_r = expected_resp_q.pop_front();
            if (got.read_data !== exp_r.read_data || got.pixel_color !== exp_r.pixel_color ||
                got.pixel_on !== exp_r.pixel_on || got.video_mode !== exp_r.video_mode ||
                got.blanked !== exp_r.blanked) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: response mismatch: exp rd=%h col=%h on=%b mode=%b ",
                              "blank=%b, got rd=%h col=%h on=%b mode=%b blank=%b"},
                             exp_r.read_data, exp_r.pixel_color, exp_r.pixel_on,
                             exp_r.video_mode, exp_r.blanked, got.read_data,
                             got.pixel_color, got.pixel_on, got.video_mode, got.blanked);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mfb_cmd_if cmd_ch ();
    mfb_res_if res_ch ();

    mono_framebuffer_video_bus dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch)
    );

    vbus_scoreboard sb;

    // Which bytes hold a known value. Reads of anything else are never issued,
    // since unwritten RAM content is not defined.
    bit                written [0:MEM_DEPTH-1];
    logic [ADDR_W-1:0] written_q[$];
    logic [ADDR_W-1:0] fb_written_q[$];   // subset inside the bitmap

    int cycle_count = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog: the slowest legal run is far below this
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout, %0d responses outstanding", sb.outstanding());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: check every transfer, then pick next ready.
    // Stall behavior switches between a few patterns every so often.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_CHOKE} rx_pattern_t;

    rx_pattern_t rx_pattern = RX_OPEN;
    int          rx_left = 0;
    int          rx_phase = 0;
    bus_resp_t   rx_got;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            rx_got.read_data   = res_ch.read_data;
            rx_got.pixel_color = res_ch.pixel_color;
            rx_got.pixel_on    = res_ch.pixel_on;
            rx_got.video_mode  = res_ch.video_mode;
            rx_got.blanked     = res_ch.blanked;
            sb.check_response(rx_got);
        end
        if (rx_left == 0) begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            rx_left    <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= (rx_phase == 23) ? 0 : rx_phase + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            case (rx_pattern)
                RX_OPEN:   res_ch.ready <= 1'b1;
                RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   res_ch.ready <= (rx_phase < 4);   // long stall, short window
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Present one command and hold it until the transfer happens
    task automatic drive_cmd(input bus_cmd_t it);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.cmd     <= it.cmd;
        cmd_ch.address <= it.address;
        cmd_ch.data    <= it.data;
        cmd_ch.pixel_x <= it.pixel_x;
        cmd_ch.pixel_y <= it.pixel_y;
        // bookkeeping for legal reads; commands go out in order so this is current
        if (it.cmd == CMD_PRELOAD ||
            (it.cmd == CMD_MEM_WR && it.address >= DEBUG_TOP && it.address >= ROM_BYTES)) begin
            if (!written[it.address]) begin
                written[it.address] = 1'b1;
                written_q.push_back(it.address);
                if (it.address >= FB_BASE && it.address < FB_END)
                    fb_written_q.push_back(it.address);
            end
        end
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.accept_command(it);
    endtask

    task automatic idle_for(input int n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every queued response has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic bus_cmd_t mk(input logic [CMD_W-1:0] c, input int a, input int d,
                                    input int px, input int py);
        bus_cmd_t it;
        it.cmd     = c;
        it.address = ADDR_W'(a);
        it.data    = DATA_W'(d);
        it.pixel_x = PIX_W'(px);
        it.pixel_y = PIX_W'(py);
        return it;
    endfunction

    // Random command mix. Reads and in-range pixel lookups only touch bytes
    // with a known value; unused fields carry random bits.
    function automatic bus_cmd_t pick_command();
        bus_cmd_t          it;
        int unsigned       r;
        int unsigned       off;
        logic [ADDR_W-1:0] a;
        it.cmd     = CMD_IO_RD;
        it.address = ADDR_W'($urandom);
        it.data    = DATA_W'($urandom);
        it.pixel_x = PIX_W'($urandom);
        it.pixel_y = PIX_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 12) begin
            it.cmd = CMD_PRELOAD;
            case ($urandom_range(0, 3))
                0, 1: it.address = ADDR_W'(int'(FB_BASE) +
                                           $urandom_range(0, FB_HEIGHT * FB_ROW_BYTES - 1));
                2:    it.address = ADDR_W'($urandom_range(0, ROM_BYTES - 1));
                default: ;
            endcase
        end else if (r < 30) begin
            it.cmd = CMD_MEM_WR;
            case ($urandom_range(0, 9))
                0:       it.address = ADDR_W'($urandom_range(0, DEBUG_TOP - 1));
                1:       it.address = ADDR_W'($urandom_range(DEBUG_TOP, ROM_BYTES - 1));
                default: ;
            endcase
        end else if (r < 52) begin
            it.cmd     = CMD_MEM_RD;
            it.address = written_q[$urandom_range(0, written_q.size() - 1)];
        end else if (r < 57) begin
            it.cmd = CMD_IO_RD;
        end else if (r < 70) begin
            it.cmd = CMD_IO_WR;
            if ($urandom_range(0, 3) != 0)
                it.address[7:0] = CTL_PORT;
        end else if (r < 95) begin
            it.cmd = CMD_PIXEL;
            if ($urandom_range(0, 3) != 0) begin
                a   = fb_written_q[$urandom_range(0, fb_written_q.size() - 1)];
                off = a - FB_BASE;
                it.pixel_y = PIX_W'(off / FB_ROW_BYTES);
                it.pixel_x = PIX_W'((off % FB_ROW_BYTES) * 8 + $urandom_range(0, 7));
            end else begin
                it.pixel_y = PIX_W'($urandom_range(FB_HEIGHT, (1 << PIX_W) - 1));
            end
        end else begin
            it.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int burst_len;
        int gap;
        int next_drain;

        sb = new();
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.cmd     <= CMD_MEM_RD;
        cmd_ch.address <= '0;
        cmd_ch.data    <= '0;
        cmd_ch.pixel_x <= '0;
        cmd_ch.pixel_y <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, back to back
        // debug window: preload reaches it, a bus write does not
        drive_cmd(mk(CMD_PRELOAD, 16'h0000, 8'hA5, 0, 0));
        drive_cmd(mk(CMD_MEM_RD,  16'h0000, 8'h00, 511, 511));
        drive_cmd(mk(CMD_PRELOAD, 16'h0002, 8'h5A, 0, 0));
        drive_cmd(mk(CMD_MEM_WR,  16'h0002, 8'h11, 0, 0));
        drive_cmd(mk(CMD_MEM_RD,  16'h0002, 8'hFF, 0, 0));
        // top byte of ROM is protected, first byte after it is RAM
        drive_cmd(mk(CMD_PRELOAD, ROM_BYTES - 1, 8'h3C, 0, 0));
        drive_cmd(mk(CMD_MEM_WR,  ROM_BYTES - 1, 8'hFF, 0, 0));
        drive_cmd(mk(CMD_MEM_RD,  ROM_BYTES - 1, 8'h00, 0, 0));
        drive_cmd(mk(CMD_MEM_WR,  ROM_BYTES, 8'h77, 0, 0));
        drive_cmd(mk(CMD_MEM_RD,  ROM_BYTES, 8'h00, 0, 0));
        drive_cmd(mk(CMD_MEM_WR,  16'hFFFF, 8'hFF, 511, 511));
        drive_cmd(mk(CMD_MEM_RD,  16'hFFFF, 8'h00, 0, 0));
        // control port: all ones, all zeros with upper address bits set,
        // then writes to other ports that must not stick
        drive_cmd(mk(CMD_IO_WR,   16'h0001, 8'hFF, 0, 0));
        drive_cmd(mk(CMD_IO_WR,   16'hFF01, 8'h00, 0, 0));
        drive_cmd(mk(CMD_IO_WR,   16'h0000, 8'hFF, 0, 0));
        drive_cmd(mk(CMD_IO_WR,   16'h0102, 8'hC0, 0, 0));
        drive_cmd(mk(CMD_IO_RD,   16'hFFFF, 8'hFF, 511, 511));
        drive_cmd(mk(CMD_IO_WR,   16'h0001, 8'h6A, 0, 0));
        // bitmap corners, LSB first within the byte
        drive_cmd(mk(CMD_PRELOAD, FB_BASE, 8'h81, 0, 0));
        drive_cmd(mk(CMD_PIXEL,   16'hFFFF, 8'hFF, 0, 0));
        drive_cmd(mk(CMD_PIXEL,   16'h0000, 8'h00, 1, 0));
        drive_cmd(mk(CMD_PRELOAD, FB_END - 1, 8'h80, 0, 0));
        drive_cmd(mk(CMD_PIXEL,   16'h0000, 8'h00, FB_WIDTH - 1, FB_HEIGHT - 1));
        // row past the bottom edge reads as black
        drive_cmd(mk(CMD_PIXEL,   16'h0000, 8'h00, FB_WIDTH - 1, FB_HEIGHT));
        drive_cmd(mk(CMD_SPARE_6, 16'hFFFF, 8'hFF, 511, 511));
        drive_cmd(mk(CMD_SPARE_7, 16'h0001, 8'hFF, 0, 0));
        drain();

        // Random bursts; mostly short, sometimes long unbroken stretches
        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RAND_ITEMS) begin
            burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 16);
            repeat (burst_len) begin
                drive_cmd(pick_command());
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
                idle_for(gap);
            if (sent >= next_drain) begin
                drain();
                next_drain += DRAIN_EVERY;
            end
        end

        drain();
        idle_for(TAIL_CYCLES);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
